/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/obbx_pkg.sv */
`default_nettype none
package obbx_pkg;

    localparam int CW    = 32;
    localparam int MW    = 24;
    localparam int FRAC  = 16;
    localparam int HALFW = CW - 1;

    // doubled centers and their difference
    localparam int C2W  = CW + 2;
    localparam int DW   = C2W + 1;
    // center projection
    localparam int CPW  = DW + MW;
    localparam int CTW  = CPW + 1;
    localparam int CTMW = CTW - 1;
    // cross products of matrix columns
    localparam int PW    = 2 * MW;
    localparam int XW    = PW + 1;
    localparam int AXW   = PW;
    localparam int SPLIT = AXW / 2;
    // radius terms
    localparam int HW2 = CW;
    localparam int LPW = HW2 + SPLIT;
    localparam int HPW = HW2 + AXW - SPLIT;
    localparam int RW  = HW2 + AXW;
    localparam int SW  = RW + 2;

    localparam int NVEC  = 4;
    localparam int NPAIR = 6;
    localparam int PAIR_I [NPAIR] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_J [NPAIR] = '{1, 2, 3, 2, 3, 3};
    localparam int PAIR_OF [NVEC][NVEC] = '{
        '{0, 0, 1, 2},
        '{0, 0, 3, 4},
        '{1, 3, 0, 5},
        '{2, 4, 5, 0}
    };

    localparam int FRONT_DEPTH = 3;
    localparam int RAD_DEPTH   = 3;
    localparam int DEC_DEPTH   = 2;

    localparam logic signed [MW-1:0] ONE = MW'(1 << FRAC);

    typedef enum logic [1:0] {
        OP_BOX   = 2'd0,
        OP_RECT  = 2'd1,
        OP_POINT = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam int CFG_IW = 3;

    typedef enum logic [CFG_IW-1:0] {
        REG_M00      = 3'd0,
        REG_M01      = 3'd1,
        REG_M10      = 3'd2,
        REG_M11      = 3'd3,
        REG_CENTER_X = 3'd4,
        REG_CENTER_Y = 3'd5,
        REG_HALF_W   = 3'd6,
        REG_HALF_H   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [MW-1:0] x;
        logic signed [MW-1:0] y;
    } vec_t;

    typedef struct packed {
        vec_t                 u;
        vec_t                 v;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic [HALFW-1:0]     hw;
        logic [HALFW-1:0]     hh;
    } obb_t;

    typedef struct packed {
        op_t  op;
        obb_t obb;
    } query_t;

    typedef struct packed {
        op_t                                   op;
        logic                                  det_nz;
        logic [NVEC-1:0][NVEC-1:0][AXW-1:0]    mag;
        logic [NVEC-1:0][CTMW-1:0]             ctm;
        logic [NVEC-1:0][HW2-1:0]              half;
    } front_t;

    typedef struct packed {
        op_t                       op;
        logic                      det_nz;
        logic [NVEC-1:0][CTMW-1:0] ctm;
    } side_t;

    typedef struct packed {
        side_t                   side;
        logic [NVEC-1:0][RW:0]   s01;
        logic [NVEC-1:0][RW:0]   s23;
    } rad_t;

endpackage
`default_nettype wire

/* rtl/oriented_box_overlap_test.sv */
// throughput: one item per cycle while the output is not stalled,
// set by the 8-stage pipeline with a valid bit per stage
// bubbles collapse; a stalled output holds only the stages that are occupied
// reset: synchronous, active low; clears all valid bits and loads a zero-size box
// config (identity matrix, zero center, zero half sizes)
`default_nettype none
module oriented_box_overlap_test (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [obbx_pkg::CFG_IW-1:0]       cfg_index,
    input  logic [obbx_pkg::CW-1:0]           cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_operation,
    input  logic signed [obbx_pkg::MW-1:0]    s_other_m00,
    input  logic signed [obbx_pkg::MW-1:0]    s_other_m01,
    input  logic signed [obbx_pkg::MW-1:0]    s_other_m10,
    input  logic signed [obbx_pkg::MW-1:0]    s_other_m11,
    input  logic signed [obbx_pkg::CW-1:0]    s_other_x,
    input  logic signed [obbx_pkg::CW-1:0]    s_other_y,
    input  logic [obbx_pkg::HALFW-1:0]        s_other_w,
    input  logic [obbx_pkg::HALFW-1:0]        s_other_h,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit
);
    import obbx_pkg::*;

    obb_t held_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg.u  <= vec_t'{x: ONE, y: '0};
            held_reg.v  <= vec_t'{x: '0, y: ONE};
            held_reg.px <= '0;
            held_reg.py <= '0;
            held_reg.hw <= '0;
            held_reg.hh <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_M00:      held_reg.u.x <= cfg_data[MW-1:0];
                REG_M01:      held_reg.u.y <= cfg_data[MW-1:0];
                REG_M10:      held_reg.v.x <= cfg_data[MW-1:0];
                REG_M11:      held_reg.v.y <= cfg_data[MW-1:0];
                REG_CENTER_X: held_reg.px  <= cfg_data;
                REG_CENTER_Y: held_reg.py  <= cfg_data;
                REG_HALF_W:   held_reg.hw  <= cfg_data[HALFW-1:0];
                REG_HALF_H:   held_reg.hh  <= cfg_data[HALFW-1:0];
                default: begin
                end
            endcase
        end
    end

    query_t query;

    always_comb begin
        query.op      = op_t'(s_operation);
        query.obb.u.x = s_other_m00;
        query.obb.u.y = s_other_m01;
        query.obb.v.x = s_other_m10;
        query.obb.v.y = s_other_m11;
        query.obb.px  = s_other_x;
        query.obb.py  = s_other_y;
        query.obb.hw  = s_other_w;
        query.obb.hh  = s_other_h;
    end

    logic   front_valid, front_ready;
    front_t front_data;
    logic   rad_valid, rad_ready;
    rad_t   rad_data;

    obbx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_query  (query),
        .held      (held_reg),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    obbx_radius u_radius (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (rad_valid),
        .out_ready (rad_ready),
        .out_data  (rad_data)
    );

    obbx_decide u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rad_valid),
        .in_ready  (rad_ready),
        .in_data   (rad_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_hit   (m_hit)
    );

endmodule
`default_nettype wire

/* rtl/obbx_front.sv */
`default_nettype none
module obbx_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  obbx_pkg::query_t  in_query,
    input  obbx_pkg::obb_t    held,
    output logic              out_valid,
    input  logic              out_ready,
    output obbx_pkg::front_t  out_data
);
    import obbx_pkg::*;

    logic [FRONT_DEPTH-1:0] v_reg;
    logic [FRONT_DEPTH-1:0] v_next;
    logic [FRONT_DEPTH-1:0] en;

    always_comb begin
        en[FRONT_DEPTH-1] = !v_reg[FRONT_DEPTH-1] || out_ready;
        for (int i = FRONT_DEPTH - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign v_next = {v_reg[FRONT_DEPTH-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= (en & v_next) | (~en & v_reg);
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[FRONT_DEPTH-1];

    // stage 1: both boxes in one form, doubled centers and their difference
    vec_t                  vec1 [NVEC];
    logic [HW2-1:0]        half1 [NVEC];
    logic signed [C2W-1:0] c2ax, c2ay, c2bx, c2by;

    always_comb begin
        vec1[0]  = held.u;
        vec1[1]  = held.v;
        half1[0] = {held.hw, 1'b0};
        half1[1] = {held.hh, 1'b0};
        c2ax = $signed({held.px[CW-1], held.px, 1'b0});
        c2ay = $signed({held.py[CW-1], held.py, 1'b0});
        case (in_query.op)
            OP_BOX: begin
                vec1[2]  = in_query.obb.u;
                vec1[3]  = in_query.obb.v;
                half1[2] = {in_query.obb.hw, 1'b0};
                half1[3] = {in_query.obb.hh, 1'b0};
                c2bx = $signed({in_query.obb.px[CW-1], in_query.obb.px, 1'b0});
                c2by = $signed({in_query.obb.py[CW-1], in_query.obb.py, 1'b0});
            end
            OP_RECT: begin
                vec1[2]  = vec_t'{x: ONE, y: '0};
                vec1[3]  = vec_t'{x: '0, y: ONE};
                half1[2] = {1'b0, in_query.obb.hw};
                half1[3] = {1'b0, in_query.obb.hh};
                c2bx = $signed({in_query.obb.px[CW-1], in_query.obb.px, 1'b0})
                     + $signed({{(C2W-HALFW){1'b0}}, in_query.obb.hw});
                c2by = $signed({in_query.obb.py[CW-1], in_query.obb.py, 1'b0})
                     + $signed({{(C2W-HALFW){1'b0}}, in_query.obb.hh});
            end
            default: begin
                vec1[2]  = vec_t'{x: ONE, y: '0};
                vec1[3]  = vec_t'{x: '0, y: ONE};
                half1[2] = '0;
                half1[3] = '0;
                c2bx = $signed({in_query.obb.px[CW-1], in_query.obb.px, 1'b0});
                c2by = $signed({in_query.obb.py[CW-1], in_query.obb.py, 1'b0});
            end
        endcase
    end

    op_t                  s1_op_reg;
    vec_t                 s1_vec_reg  [NVEC];
    logic [HW2-1:0]       s1_half_reg [NVEC];
    logic signed [DW-1:0] s1_dx_reg;
    logic signed [DW-1:0] s1_dy_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_op_reg <= in_query.op;
            for (int k = 0; k < NVEC; k++) begin
                s1_vec_reg[k]  <= vec1[k];
                s1_half_reg[k] <= half1[k];
            end
            s1_dx_reg <= $signed({c2bx[C2W-1], c2bx}) - $signed({c2ax[C2W-1], c2ax});
            s1_dy_reg <= $signed({c2by[C2W-1], c2by}) - $signed({c2ay[C2W-1], c2ay});
        end
    end

    // stage 2: products
    op_t                   s2_op_reg;
    logic [HW2-1:0]        s2_half_reg [NVEC];
    logic signed [PW-1:0]  s2_pa_reg [NPAIR];
    logic signed [PW-1:0]  s2_pb_reg [NPAIR];
    logic signed [CPW-1:0] s2_ca_reg [NVEC];
    logic signed [CPW-1:0] s2_cb_reg [NVEC];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s2_op_reg <= s1_op_reg;
            for (int p = 0; p < NPAIR; p++) begin
                s2_pa_reg[p] <= PW'($signed(s1_vec_reg[PAIR_I[p]].x))
                              * PW'($signed(s1_vec_reg[PAIR_J[p]].y));
                s2_pb_reg[p] <= PW'($signed(s1_vec_reg[PAIR_I[p]].y))
                              * PW'($signed(s1_vec_reg[PAIR_J[p]].x));
            end
            for (int k = 0; k < NVEC; k++) begin
                s2_half_reg[k] <= s1_half_reg[k];
                s2_ca_reg[k]   <= CPW'($signed(s1_vec_reg[k].x)) * CPW'(s1_dy_reg);
                s2_cb_reg[k]   <= CPW'($signed(s1_vec_reg[k].y)) * CPW'(s1_dx_reg);
            end
        end
    end

    // stage 3: differences and magnitudes
    logic signed [XW-1:0]  cr     [NPAIR];
    logic signed [XW-1:0]  cr_abs [NPAIR];
    logic signed [CTW-1:0] ct     [NVEC];
    logic signed [CTW-1:0] ct_abs [NVEC];
    front_t                s3_next;
    front_t                s3_reg;

    always_comb begin
        for (int p = 0; p < NPAIR; p++) begin
            cr[p]     = XW'(s2_pa_reg[p]) - XW'(s2_pb_reg[p]);
            cr_abs[p] = cr[p][XW-1] ? -cr[p] : cr[p];
        end
        s3_next.op     = s2_op_reg;
        s3_next.det_nz = (cr[0] != '0);
        for (int k = 0; k < NVEC; k++) begin
            ct[k]     = CTW'(s2_ca_reg[k]) - CTW'(s2_cb_reg[k]);
            ct_abs[k] = ct[k][CTW-1] ? -ct[k] : ct[k];
            s3_next.ctm[k]  = ct_abs[k][CTMW-1:0];
            s3_next.half[k] = s2_half_reg[k];
            for (int j = 0; j < NVEC; j++) begin
                if (k == j) begin
                    s3_next.mag[k][j] = '0;
                end else begin
                    s3_next.mag[k][j] = cr_abs[PAIR_OF[k][j]][AXW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s3_reg <= s3_next;
        end
    end

    assign out_data = s3_reg;

endmodule
`default_nettype wire

/* rtl/obbx_radius.sv */
`default_nettype none
module obbx_radius (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  obbx_pkg::front_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output obbx_pkg::rad_t    out_data
);
    import obbx_pkg::*;

    logic [RAD_DEPTH-1:0] v_reg;
    logic [RAD_DEPTH-1:0] v_next;
    logic [RAD_DEPTH-1:0] en;

    always_comb begin
        en[RAD_DEPTH-1] = !v_reg[RAD_DEPTH-1] || out_ready;
        for (int i = RAD_DEPTH - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign v_next = {v_reg[RAD_DEPTH-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= (en & v_next) | (~en & v_reg);
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[RAD_DEPTH-1];

    // stage 1: half size times projected column, in two halves
    side_t          r1_side_reg;
    logic [LPW-1:0] r1_lo_reg [NVEC][NVEC];
    logic [HPW-1:0] r1_hi_reg [NVEC][NVEC];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            r1_side_reg.op     <= in_data.op;
            r1_side_reg.det_nz <= in_data.det_nz;
            r1_side_reg.ctm    <= in_data.ctm;
            for (int k = 0; k < NVEC; k++) begin
                for (int j = 0; j < NVEC; j++) begin
                    r1_lo_reg[k][j] <= LPW'(in_data.half[j])
                                     * LPW'(in_data.mag[k][j][SPLIT-1:0]);
                    r1_hi_reg[k][j] <= HPW'(in_data.half[j])
                                     * HPW'(in_data.mag[k][j][AXW-1:SPLIT]);
                end
            end
        end
    end

    // stage 2: join halves
    side_t         r2_side_reg;
    logic [RW-1:0] r2_term_reg [NVEC][NVEC];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            r2_side_reg <= r1_side_reg;
            for (int k = 0; k < NVEC; k++) begin
                for (int j = 0; j < NVEC; j++) begin
                    r2_term_reg[k][j] <= {r1_hi_reg[k][j], {SPLIT{1'b0}}}
                                       + RW'(r1_lo_reg[k][j]);
                end
            end
        end
    end

    // stage 3: per-box radius
    rad_t r3_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            r3_reg.side <= r2_side_reg;
            for (int k = 0; k < NVEC; k++) begin
                r3_reg.s01[k] <= {1'b0, r2_term_reg[k][0]} + {1'b0, r2_term_reg[k][1]};
                r3_reg.s23[k] <= {1'b0, r2_term_reg[k][2]} + {1'b0, r2_term_reg[k][3]};
            end
        end
    end

    assign out_data = r3_reg;

endmodule
`default_nettype wire

/* rtl/obbx_decide.sv */
`default_nettype none
module obbx_decide (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  obbx_pkg::rad_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_hit
);
    import obbx_pkg::*;

    logic [DEC_DEPTH-1:0] v_reg;
    logic [DEC_DEPTH-1:0] v_next;
    logic [DEC_DEPTH-1:0] en;

    always_comb begin
        en[DEC_DEPTH-1] = !v_reg[DEC_DEPTH-1] || out_ready;
        for (int i = DEC_DEPTH - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign v_next = {v_reg[DEC_DEPTH-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= (en & v_next) | (~en & v_reg);
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[DEC_DEPTH-1];

    // stage 1: strict separation test on each axis
    logic [SW-1:0]   total [NVEC];
    logic [SW-1:0]   lhs   [NVEC];
    logic [NVEC-1:0] sep_next;

    always_comb begin
        for (int k = 0; k < NVEC; k++) begin
            total[k]    = SW'(in_data.s01[k]) + SW'(in_data.s23[k]);
            lhs[k]      = SW'({in_data.side.ctm[k], {FRAC{1'b0}}});
            sep_next[k] = lhs[k] > total[k];
        end
    end

    logic [NVEC-1:0] d1_sep_reg;
    op_t             d1_op_reg;
    logic            d1_det_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            d1_sep_reg <= sep_next;
            d1_op_reg  <= in_data.side.op;
            d1_det_reg <= in_data.side.det_nz;
        end
    end

    // stage 2: result register
    logic hit_next;
    logic hit_reg;

    always_comb begin
        case (d1_op_reg)
            OP_BOX, OP_RECT: hit_next = ~|d1_sep_reg;
            OP_POINT:        hit_next = d1_det_reg && !d1_sep_reg[0] && !d1_sep_reg[1];
            OP_NONE:         hit_next = 1'b0;
            default:         hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            hit_reg <= hit_next;
        end
    end

    assign out_hit = hit_reg;

endmodule
`default_nettype wire

/* rtl/obbx_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module obbx_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_hit
);

    // reset empties the pipeline
    `ASSERT_ANY(a_reset_clears, !aresetn |=> !m_valid, "result valid right after reset")

    // an empty output register frees every stage behind it
    `ASSERT_RST(a_ready_when_empty, !m_valid |-> s_ready, "input stalled with output empty")

    `ASSERT_RST(a_result_holds, m_valid && !m_ready |=> m_valid && $stable(m_hit), "stalled result changed")

endmodule

bind oriented_box_overlap_test obbx_checker u_obbx_checker (.*);
`default_nettype wire

/* dv/oriented_box_overlap_test_test.sv */
`timescale 1ns / 100ps
module oriented_box_overlap_test_test;
    import obbx_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef wide_t quad_t [4];

    typedef struct {
        longint m00, m01, m10, m11, cx, cy, hw, hh;
    } box_s;

    typedef struct {
        op_t                  op;
        logic signed [MW-1:0] m00, m01, m10, m11;
        logic signed [CW-1:0] x, y;
        logic [HALFW-1:0]     w, h;
    } query_s;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IW-1:0]    cfg_index = '0;
    logic [CW-1:0]        cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_operation = '0;
    logic signed [MW-1:0] s_other_m00 = '0, s_other_m01 = '0, s_other_m10 = '0;
    logic signed [MW-1:0] s_other_m11 = '0;
    logic signed [CW-1:0] s_other_x = '0, s_other_y = '0;
    logic [HALFW-1:0]     s_other_w = '0, s_other_h = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_hit;

    oriented_box_overlap_test dut (.*);

    always #5 aclk = ~aclk;

    box_s   held_box;
    query_s pending_q[$];
    query_s cur_query;
    bit     hit_q[$];
    bit     took = 0;
    bit     idle_on = 1;
    bit     long_hold_req = 0;
    int     send_gap = 0;
    int     recv_gap = 0;
    int     hold_cnt = 0;
    int     mismatches = 0;
    int     n_in = 0, n_out = 0, n_hits = 0, n_cfg = 0;
    int     quiet = 0;

    function automatic void box_corners(box_s b, output quad_t qx, output quad_t qy);
        wide_t ux, uy, vx, vy, tx, ty;
        bit    pu, pv;
        ux = wide_t'(b.m00) * wide_t'(b.hw);
        uy = wide_t'(b.m01) * wide_t'(b.hw);
        vx = wide_t'(b.m10) * wide_t'(b.hh);
        vy = wide_t'(b.m11) * wide_t'(b.hh);
        tx = wide_t'(b.cx) * 65536;
        ty = wide_t'(b.cy) * 65536;
        for (int i = 0; i < 4; i++) begin
            pu = (i == 1 || i == 2);
            pv = (i >= 2);
            qx[i] = tx + (pu ? ux : -ux) + (pv ? vx : -vx);
            qy[i] = ty + (pu ? uy : -uy) + (pv ? vy : -vy);
        end
    endfunction

    function automatic bit is_split(quad_t ax, quad_t ay, quad_t bx, quad_t by,
                                    longint dx, longint dy);
        wide_t amn, amx, bmn, bmx, p;
        for (int i = 0; i < 4; i++) begin
            p = ax[i] * wide_t'(dx) + ay[i] * wide_t'(dy);
            if (i == 0 || p < amn) amn = p;
            if (i == 0 || p > amx) amx = p;
            p = bx[i] * wide_t'(dx) + by[i] * wide_t'(dy);
            if (i == 0 || p < bmn) bmn = p;
            if (i == 0 || p > bmx) bmx = p;
        end
        return (amx < bmn) || (bmx < amn);
    endfunction

    function automatic bit split_by_axes(quad_t ax, quad_t ay, quad_t bx, quad_t by,
                                         box_s o);
        return is_split(ax, ay, bx, by, -o.m01, o.m00) ||
               is_split(ax, ay, bx, by, -o.m11, o.m10);
    endfunction

    function automatic bit overlap_hit(query_s q);
        box_s   o;
        quad_t  ax, ay, bx, by;
        wide_t  det, ad, lx, ly, qx, qy;
        longint x, y, w, h;
        x = longint'(q.x);
        y = longint'(q.y);
        w = longint'(q.w);
        h = longint'(q.h);
        case (q.op)
            OP_BOX: begin
                o = '{longint'(q.m00), longint'(q.m01), longint'(q.m10), longint'(q.m11),
                      x, y, w, h};
                box_corners(held_box, ax, ay);
                box_corners(o, bx, by);
                return !split_by_axes(ax, ay, bx, by, held_box) &&
                       !split_by_axes(ax, ay, bx, by, o);
            end
            OP_RECT: begin
                bx[0] = wide_t'(x) * 65536;     by[0] = wide_t'(y) * 65536;
                bx[1] = wide_t'(x + w) * 65536; by[1] = by[0];
                bx[2] = bx[1];                  by[2] = wide_t'(y + h) * 65536;
                bx[3] = bx[0];                  by[3] = by[2];
                box_corners(held_box, ax, ay);
                return !is_split(bx, by, ax, ay, 1, 0) && !is_split(bx, by, ax, ay, 0, 1) &&
                       !split_by_axes(bx, by, ax, ay, held_box);
            end
            OP_POINT: begin
                qx = wide_t'(x - held_box.cx);
                qy = wide_t'(y - held_box.cy);
                det = wide_t'(held_box.m00) * wide_t'(held_box.m11) -
                      wide_t'(held_box.m01) * wide_t'(held_box.m10);
                if (det == 0) return 0;
                ad = det < 0 ? -det : det;
                lx = qx * wide_t'(held_box.m11) - qy * wide_t'(held_box.m10);
                ly = qy * wide_t'(held_box.m00) - qx * wide_t'(held_box.m01);
                if (lx < 0) lx = -lx;
                if (ly < 0) ly = -ly;
                if (ad * wide_t'(held_box.hw) < lx * 65536) return 0;
                if (ad * wide_t'(held_box.hh) < ly * 65536) return 0;
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CW-1:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            REG_M00:      held_box.m00 = longint'($signed(v[MW-1:0]));
            REG_M01:      held_box.m01 = longint'($signed(v[MW-1:0]));
            REG_M10:      held_box.m10 = longint'($signed(v[MW-1:0]));
            REG_M11:      held_box.m11 = longint'($signed(v[MW-1:0]));
            REG_CENTER_X: held_box.cx = longint'($signed(v));
            REG_CENTER_Y: held_box.cy = longint'($signed(v));
            REG_HALF_W:   held_box.hw = longint'(v[HALFW-1:0]);
            REG_HALF_H:   held_box.hh = longint'(v[HALFW-1:0]);
            default: begin
            end
        endcase
        n_cfg++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_valid || hit_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    function automatic longint near(longint c, int span);
        return c + longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic query_s make_query(bit wild);
        query_s q;
        int     r;
        r = $urandom_range(0, 9);
        q.op = r < 4 ? OP_BOX : r < 7 ? OP_RECT : r < 9 ? OP_POINT : OP_NONE;
        if (wild) begin
            q.m00 = MW'($urandom); q.m01 = MW'($urandom);
            q.m10 = MW'($urandom); q.m11 = MW'($urandom);
            q.x = $urandom; q.y = $urandom;
            q.w = HALFW'($urandom); q.h = HALFW'($urandom);
        end else begin
            q.m00 = MW'(near(0, 1 << 17)); q.m01 = MW'(near(0, 1 << 17));
            q.m10 = MW'(near(0, 1 << 17)); q.m11 = MW'(near(0, 1 << 17));
            q.x = CW'(near(held_box.cx, 1 << 15));
            q.y = CW'(near(held_box.cy, 1 << 15));
            q.w = HALFW'($urandom_range(0, 1 << 14));
            q.h = HALFW'($urandom_range(0, 1 << 14));
        end
        return q;
    endfunction

    function automatic query_s mk(op_t op, longint a, longint b, longint c, longint d,
                                  longint x, longint y, longint w, longint h);
        query_s q;
        q = '{op, MW'(a), MW'(b), MW'(c), MW'(d), CW'(x), CW'(y), HALFW'(w), HALFW'(h)};
        return q;
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !took) begin
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                cur_query = pending_q.pop_front();
                s_operation <= cur_query.op;
                s_other_m00 <= cur_query.m00;
                s_other_m01 <= cur_query.m01;
                s_other_m10 <= cur_query.m10;
                s_other_m11 <= cur_query.m11;
                s_other_x <= cur_query.x;
                s_other_y <= cur_query.y;
                s_other_w <= cur_query.w;
                s_other_h <= cur_query.h;
                s_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 13);
            end else begin
                s_valid <= 1'b0;
            end
            took = 0;
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (long_hold_req) begin
                long_hold_req = 0;
                hold_cnt = 300;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 13);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        bit want;
        if (aresetn) begin
            quiet++;
            if (s_valid && s_ready) begin
                took = 1;
                hit_q.push_back(overlap_hit(cur_query));
                n_in++;
                quiet = 0;
            end
            if (m_valid && m_ready) begin
                quiet = 0;
                n_out++;
                if (m_hit === 1'b1) n_hits++;
                if (hit_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transfer, hit %b", m_hit);
                end else begin
                    want = hit_q.pop_front();
                    if (m_hit !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("hit mismatch at result %0d: expected %b, got %b",
                                     n_out, want, m_hit);
                    end
                end
            end
            if (quiet > 5000) begin
                $display("timeout: no transfer for %0d cycles", quiet);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        held_box = '{65536, 0, 0, 65536, 0, 0, 0, 0};
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset box is a single point at the origin
        pending_q.push_back(mk(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(OP_POINT, 0, 0, 0, 0, 1, 0, 0, 0));
        pending_q.push_back(mk(OP_BOX, 65536, 0, 0, 65536, 0, 0, 0, 0));
        pending_q.push_back(mk(OP_BOX, 65536, 0, 0, 65536, 256, 0, 255, 0));
        pending_q.push_back(mk(OP_BOX, 65536, 0, 0, 65536, 256, 0, 256, 0));
        pending_q.push_back(mk(OP_BOX, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(OP_BOX, -8388608, 8388607, 8388607, -8388608,
                               -2147483648, 2147483647, 2147483647, 2147483647));
        pending_q.push_back(mk(OP_RECT, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(OP_RECT, 0, 0, 0, 0, -256, -256, 256, 256));
        pending_q.push_back(mk(OP_RECT, 0, 0, 0, 0, 1, 0, 100, 100));
        pending_q.push_back(mk(OP_RECT, 0, 0, 0, 0, -2147483648, -2147483648,
                               2147483647, 2147483647));
        pending_q.push_back(mk(OP_RECT, 0, 0, 0, 0, 2147483647, 2147483647,
                               2147483647, 2147483647));
        pending_q.push_back(mk(OP_NONE, -1, -1, -1, -1, 0, 0, 0, 0));
        pending_q.push_back(mk(OP_POINT, 0, 0, 0, 0, -2147483648, 2147483647, 0, 0));
        wait_drained();

        write_reg(REG_M00, CW'(-8388608));
        write_reg(REG_M01, CW'(8388607));
        write_reg(REG_M10, CW'(8388607));
        write_reg(REG_M11, CW'(-8388608));
        write_reg(REG_CENTER_X, CW'(-2147483648));
        write_reg(REG_CENTER_Y, CW'(2147483647));
        write_reg(REG_HALF_W, CW'(2147483647));
        write_reg(REG_HALF_H, CW'(2147483647));
        pending_q.push_back(mk(OP_POINT, 0, 0, 0, 0, -2147483648, 2147483647, 0, 0));
        pending_q.push_back(mk(OP_POINT, 0, 0, 0, 0, 2147483647, -2147483648, 0, 0));
        pending_q.push_back(mk(OP_BOX, -8388608, 8388607, 8388607, -8388608,
                               2147483647, -2147483648, 2147483647, 2147483647));
        pending_q.push_back(mk(OP_RECT, 0, 0, 0, 0, -2147483648, -2147483648,
                               2147483647, 2147483647));
        wait_drained();

        // zero determinant and a degenerate column
        write_reg(REG_M00, CW'(65536));
        write_reg(REG_M01, CW'(65536));
        write_reg(REG_M10, CW'(0));
        write_reg(REG_M11, CW'(0));
        write_reg(REG_CENTER_X, CW'(0));
        write_reg(REG_CENTER_Y, CW'(0));
        write_reg(REG_HALF_W, CW'(1024));
        write_reg(REG_HALF_H, CW'(1024));
        pending_q.push_back(mk(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(OP_BOX, 65536, 0, 0, 65536, 512, 512, 256, 256));
        pending_q.push_back(mk(OP_RECT, 0, 0, 0, 0, 0, 0, 512, 512));
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            idle_on = (ph < 7);
            write_reg(REG_M00, CW'(near(0, 1 << 17)));
            write_reg(REG_M01, CW'(near(0, 1 << 17)));
            write_reg(REG_M10, CW'(near(0, 1 << 17)));
            write_reg(REG_M11, CW'(near(0, 1 << 17)));
            write_reg(REG_CENTER_X, $urandom_range(0, 1) ? $urandom : CW'(near(0, 1 << 16)));
            write_reg(REG_CENTER_Y, $urandom_range(0, 1) ? $urandom : CW'(near(0, 1 << 16)));
            write_reg(REG_HALF_W, $urandom_range(0, 1 << 14));
            write_reg(REG_HALF_H, $urandom_range(0, 1 << 14));
            if (ph == 3) long_hold_req = 1;
            for (int i = 0; i < 50; i++)
                pending_q.push_back(make_query($urandom_range(0, 9) == 0));
            wait_drained();
        end

        $display("%0d queries and %0d results (%0d hits), %0d register writes",
                 n_in, n_out, n_hits, n_cfg);
        if (mismatches == 0 && hit_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, hit_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/obbx_pkg.sv
rtl/obbx_front.sv
rtl/obbx_radius.sv
rtl/obbx_decide.sv
rtl/oriented_box_overlap_test.sv
rtl/obbx_checker.sv
dv/oriented_box_overlap_test_test.sv
